>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> sv/y2i_pkg.sv
`timescale 1ns / 1ps

package y2i_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // register file
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // effective sizes carry one extra bit so a large MAX_* still fits
    localparam int EXT_W     = CFG_W + 1;
    localparam int AREA_W    = 2 * EXT_W;
    localparam int WIDTH_TOP = (MAX_WIDTH / 2) * 2;

    localparam int PAIR_SLOTS = MAX_WIDTH / 2;
    localparam int COL_W      = $clog2(PAIR_SLOTS);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LUMA_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int CHROMA_W   = LUMA_W - 2;

    localparam int BYTE_W = 8;
    localparam int OFF_W  = 25;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // result slots of one word
    localparam logic [1:0] PH_Y0 = 2'd0;
    localparam logic [1:0] PH_Y1 = 2'd1;
    localparam logic [1:0] PH_U  = 2'd2;
    localparam logic [1:0] PH_V  = 2'd3;

    typedef struct packed {
        logic                odd;
        logic [BYTE_W-1:0]   y0;
        logic [BYTE_W-1:0]   y1;
        logic [BYTE_W-1:0]   u;
        logic [BYTE_W-1:0]   v;
        logic [LUMA_W-1:0]   luma;
        logic [CHROMA_W-1:0] chroma;
    } y2i_job_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } y2i_qstat_t;

    function automatic logic [EXT_W-1:0] eff_width(input logic [CFG_W-1:0] cfg);
        logic [EXT_W-1:0] w;
        w = {1'b0, cfg[CFG_W-1:1], 1'b0};
        if (w < EXT_W'(2))
            w = EXT_W'(2);
        if (w > EXT_W'(WIDTH_TOP))
            w = EXT_W'(WIDTH_TOP);
        return w;
    endfunction

    function automatic logic [EXT_W-1:0] eff_height(input logic [CFG_W-1:0] cfg);
        logic [EXT_W-1:0] h;
        h = {1'b0, cfg};
        if (h < EXT_W'(2))
            h = EXT_W'(2);
        if (h > EXT_W'(MAX_HEIGHT))
            h = EXT_W'(MAX_HEIGHT);
        return h;
    endfunction

endpackage

>>> sv/y2i_front.sv
`timescale 1ns / 1ps

module y2i_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [y2i_pkg::CFG_W-1:0]   frame_width,
    input  logic [y2i_pkg::CFG_W-1:0]   frame_height,
    input  logic                        push,
    output logic                        full,
    input  logic [y2i_pkg::BYTE_W-1:0]  luma_first,
    input  logic [y2i_pkg::BYTE_W-1:0]  chroma_blue,
    input  logic [y2i_pkg::BYTE_W-1:0]  luma_second,
    input  logic [y2i_pkg::BYTE_W-1:0]  chroma_red,
    input  y2i_pkg::y2i_qstat_t         qstat,
    output logic                        q_push,
    output y2i_pkg::y2i_job_t           q_job
);
    import y2i_pkg::*;

    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [LUMA_W-1:0]   luma_reg, luma_next;
    logic [CHROMA_W-1:0] chroma_reg, chroma_next;
    logic                s1_valid_reg, s1_valid_next;
    y2i_job_t            s1_job_reg;
    logic [2*BYTE_W-1:0] rd_data_reg;
    logic [2*BYTE_W-1:0] line_mem [PAIR_SLOTS];

    logic                accept;
    logic                odd_row;
    logic [EXT_W-1:0]    w_eff, h_eff;
    logic [EXT_W-2:0]    pairs;
    logic [COL_W:0]      col_inc;
    logic [ROW_W:0]      row_inc;
    logic [BYTE_W:0]     u_sum, v_sum;

    assign full    = s1_valid_reg & qstat.full;
    assign accept  = push & ~full;
    assign q_push  = s1_valid_reg & ~qstat.full;
    assign odd_row = row_reg[0];

    assign w_eff   = eff_width(frame_width);
    assign h_eff   = eff_height(frame_height);
    assign pairs   = w_eff[EXT_W-1:1];
    assign col_inc = {1'b0, col_reg} + (COL_W+1)'(1);
    assign row_inc = {1'b0, row_reg} + (ROW_W+1)'(1);

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        luma_next   = luma_reg;
        chroma_next = chroma_reg;
        if (accept)
        begin
            luma_next = luma_reg + LUMA_W'(2);
            if (odd_row)
                chroma_next = chroma_reg + CHROMA_W'(1);
            col_next = col_inc[COL_W-1:0];
            // >= so a smaller width ends the row, a smaller height the frame
            if ((EXT_W-1)'(col_inc) >= pairs)
            begin
                col_next = '0;
                row_next = row_inc[ROW_W-1:0];
                if (EXT_W'(row_inc) >= h_eff)
                begin
                    row_next    = '0;
                    luma_next   = '0;
                    chroma_next = '0;
                end
            end
        end
        s1_valid_next = accept | (s1_valid_reg & qstat.full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            luma_reg     <= '0;
            chroma_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            luma_reg     <= luma_next;
            chroma_reg   <= chroma_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_job_reg.odd    <= odd_row;
            s1_job_reg.y0     <= luma_first;
            s1_job_reg.y1     <= luma_second;
            s1_job_reg.u      <= chroma_blue;
            s1_job_reg.v      <= chroma_red;
            s1_job_reg.luma   <= luma_reg;
            s1_job_reg.chroma <= chroma_reg;
        end
    end

    // line store: U low byte, V high byte; written on even rows
    always_ff @(posedge clk)
    begin
        if (accept && !odd_row)
            line_mem[col_reg] <= {chroma_red, chroma_blue};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= line_mem[col_reg];
    end

    assign u_sum = {1'b0, rd_data_reg[BYTE_W-1:0]} + {1'b0, s1_job_reg.u};
    assign v_sum = {1'b0, rd_data_reg[2*BYTE_W-1:BYTE_W]} + {1'b0, s1_job_reg.v};

    always_comb
    begin
        q_job   = s1_job_reg;
        q_job.u = u_sum[BYTE_W:1];
        q_job.v = v_sum[BYTE_W:1];
    end

endmodule

>>> sv/y2i_fifo.sv
`timescale 1ns / 1ps

module y2i_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  y2i_pkg::y2i_job_t    job_in,
    input  logic                 pop,
    output y2i_pkg::y2i_job_t    job_out,
    output y2i_pkg::y2i_qstat_t  qstat
);
    import y2i_pkg::*;

    y2i_job_t              entries [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign qstat.full     = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign qstat.nonempty = (count_reg != '0);
    assign do_push        = push & ~qstat.full;
    assign do_pop         = pop & qstat.nonempty;
    assign job_out        = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (FIFO_PTR_W+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (FIFO_PTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= job_in;
    end

endmodule

>>> sv/y2i_back.sv
`timescale 1ns / 1ps

module y2i_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  y2i_pkg::y2i_job_t           job,
    input  y2i_pkg::y2i_qstat_t         qstat,
    output logic                        q_pop,
    input  logic [y2i_pkg::OFF_W-1:0]   u_base,
    input  logic [y2i_pkg::OFF_W-1:0]   v_base,
    input  logic                        pop,
    output logic                        empty,
    output logic [y2i_pkg::OFF_W-1:0]   byte_offset,
    output logic [y2i_pkg::BYTE_W-1:0]  byte_value,
    output logic                        last_of_run
);
    import y2i_pkg::*;

    logic [1:0]        phase_reg, phase_next;
    logic              out_valid_reg, out_valid_next;
    logic [OFF_W-1:0]  offset_reg;
    logic [BYTE_W-1:0] value_reg;
    logic              last_reg;

    logic              load;
    logic              last_now;
    logic [OFF_W-1:0]  add_a, add_b;
    logic [BYTE_W-1:0] value_sel;

    assign load     = qstat.nonempty & (~out_valid_reg | pop);
    assign last_now = job.odd ? (phase_reg == PH_V) : (phase_reg == PH_Y1);
    assign q_pop    = load & last_now;

    always_comb
    begin
        case (phase_reg)
            PH_Y0:
            begin
                add_a     = OFF_W'(job.luma);
                add_b     = '0;
                value_sel = job.y0;
            end
            PH_Y1:
            begin
                add_a     = OFF_W'(job.luma);
                add_b     = OFF_W'(1);
                value_sel = job.y1;
            end
            PH_U:
            begin
                add_a     = u_base;
                add_b     = OFF_W'(job.chroma);
                value_sel = job.u;
            end
            PH_V:
            begin
                add_a     = v_base;
                add_b     = OFF_W'(job.chroma);
                value_sel = job.v;
            end
            default:
            begin
                add_a     = '0;
                add_b     = '0;
                value_sel = '0;
            end
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg & ~pop;
        if (load)
        begin
            phase_next     = last_now ? PH_Y0 : phase_reg + 2'd1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_Y0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            offset_reg <= add_a + add_b;
            value_reg  <= value_sel;
            last_reg   <= last_now;
        end
    end

    assign empty       = ~out_valid_reg;
    assign byte_offset = offset_reg;
    assign byte_value  = value_reg;
    assign last_of_run = last_reg;

endmodule

>>> sv/yuyv_packed_to_i420_planar.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// input     push / full          luma_first, chroma_blue, luma_second, chroma_red
// result    empty / pop          byte_offset, byte_value, last_of_run
// config    cfg_write            cfg_index, cfg_data
//
// One result per cycle while pop is high: an even-row word gives 2 results, an odd-row word 4.
// The result-side sequencer sets that rate; the input side takes one word a cycle while full
// is low into a 4-entry queue; a word passes the front stage and the queue to the ports.
// Reset clears counters and queue; the line store is not cleared.
// full rises only when the queue is full and a word waits in the front stage.

module yuyv_packed_to_i420_planar (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [y2i_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [y2i_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [y2i_pkg::BYTE_W-1:0]    luma_first,
    input  logic [y2i_pkg::BYTE_W-1:0]    chroma_blue,
    input  logic [y2i_pkg::BYTE_W-1:0]    luma_second,
    input  logic [y2i_pkg::BYTE_W-1:0]    chroma_red,
    output logic                          empty,
    input  logic                          pop,
    output logic [y2i_pkg::OFF_W-1:0]     byte_offset,
    output logic [y2i_pkg::BYTE_W-1:0]    byte_value,
    output logic                          last_of_run
);
    import y2i_pkg::*;

    `include "assert_macros.svh"

    logic [CFG_W-1:0]  frame_width_reg;
    logic [CFG_W-1:0]  frame_height_reg;
    logic [AREA_W-1:0] area_reg, area_next;
    logic [OFF_W-1:0]  v_base_reg, v_base_next;
    logic [AREA_W:0]   v_sum;

    y2i_qstat_t        qstat;
    y2i_job_t          q_in_job, q_out_job;
    logic              q_push, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // U base (area_reg) is registered from the size registers, V base (v_base_reg) is registered from U base
    assign area_next   = AREA_W'(eff_width(frame_width_reg) * eff_height(frame_height_reg));
    assign v_sum       = {1'b0, area_reg} + {3'b000, area_reg[AREA_W-1:2]};
    assign v_base_next = v_sum[OFF_W-1:0];

    always_ff @(posedge clk)
    begin
        area_reg   <= area_next;
        v_base_reg <= v_base_next;
    end

    y2i_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .push         (push),
        .full         (full),
        .luma_first   (luma_first),
        .chroma_blue  (chroma_blue),
        .luma_second  (luma_second),
        .chroma_red   (chroma_red),
        .qstat        (qstat),
        .q_push       (q_push),
        .q_job        (q_in_job)
    );

    y2i_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .job_in  (q_in_job),
        .pop     (q_pop),
        .job_out (q_out_job),
        .qstat   (qstat)
    );

    y2i_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (q_out_job),
        .qstat       (qstat),
        .q_pop       (q_pop),
        .u_base      (area_reg[OFF_W-1:0]),
        .v_base      (v_base_reg),
        .pop         (pop),
        .empty       (empty),
        .byte_offset (byte_offset),
        .byte_value  (byte_value),
        .last_of_run (last_of_run)
    );

    `ASSERT_IMPL(a_full_means_queue_full, clk, rst_n, full, qstat.full)
    `ASSERT_IMPL(a_no_queue_overflow, clk, rst_n, qstat.full, !q_push)
    `ASSERT_NEXT(a_run_is_contiguous, clk, rst_n, (!empty && pop && !last_of_run), !empty)

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

typedef struct {
    logic [y2i_pkg::OFF_W-1:0]  offset;
    logic [y2i_pkg::BYTE_W-1:0] value;
    logic                       last;
} planar_byte_t;

// Tracks the frame position and the chroma line of the converter and keeps
// the bytes still owed on the output side, oldest first.
class i420_tracker;
    planar_byte_t due_bytes[$];
    logic [y2i_pkg::CFG_W-1:0] width_reg;
    logic [y2i_pkg::CFG_W-1:0] height_reg;
    int col;
    int row;
    int luma_pos;
    int chroma_pos;
    logic [15:0] chroma_row [y2i_pkg::PAIR_SLOTS];
    bit filled [y2i_pkg::PAIR_SLOTS];
    int errors;

    function new();
        width_reg = y2i_pkg::FRAME_WIDTH_RST;
        height_reg = y2i_pkg::FRAME_HEIGHT_RST;
        col = 0;
        row = 0;
        luma_pos = 0;
        chroma_pos = 0;
        errors = 0;
        foreach (filled[i])
            filled[i] = 1'b0;
    endfunction

    function int span_of(logic [y2i_pkg::CFG_W-1:0] cfg);
        int w;
        w = int'(cfg) & ~1;
        if (w < 2)
            w = 2;
        if (w > (y2i_pkg::MAX_WIDTH / 2) * 2)
            w = (y2i_pkg::MAX_WIDTH / 2) * 2;
        return w;
    endfunction

    function int rows_of(logic [y2i_pkg::CFG_W-1:0] cfg);
        int h;
        h = int'(cfg);
        if (h < 2)
            h = 2;
        if (h > y2i_pkg::MAX_HEIGHT)
            h = y2i_pkg::MAX_HEIGHT;
        return h;
    endfunction

    function bit at_frame_start();
        return col == 0 && row == 0;
    endfunction

    // A width change must never lead to a read of a line store slot that
    // was never written.
    function bit width_ok(logic [y2i_pkg::CFG_W-1:0] cfg);
        int pairs;
        int i;
        pairs = span_of(cfg) / 2;
        if (at_frame_start())
            return 1'b1;
        if (row[0] && !filled[col % y2i_pkg::PAIR_SLOTS])
            return 1'b0;
        for (i = 0; i < pairs; i++)
            if (!filled[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function void queue_byte(int off, int val, bit last);
        planar_byte_t b;
        b.offset = off[y2i_pkg::OFF_W-1:0];
        b.value = val[7:0];
        b.last = last;
        due_bytes.push_back(b);
    endfunction

    function void take_word(logic [7:0] y0, logic [7:0] u, logic [7:0] y1, logic [7:0] v);
        int w;
        int h;
        int slot;
        int area;
        logic [8:0] u_sum;
        logic [8:0] v_sum;
        w = span_of(width_reg);
        h = rows_of(height_reg);
        slot = col % y2i_pkg::PAIR_SLOTS;
        if (row[0] == 1'b0) begin
            queue_byte(luma_pos, y0, 1'b0);
            queue_byte(luma_pos + 1, y1, 1'b1);
            chroma_row[slot] = {v, u};
            filled[slot] = 1'b1;
        end
        else begin
            u_sum = u + chroma_row[slot][7:0];
            v_sum = v + chroma_row[slot][15:8];
            area = w * h;
            queue_byte(luma_pos, y0, 1'b0);
            queue_byte(luma_pos + 1, y1, 1'b0);
            queue_byte(area + chroma_pos, u_sum[8:1], 1'b0);
            queue_byte(area * 5 / 4 + chroma_pos, v_sum[8:1], 1'b1);
            chroma_pos++;
        end
        luma_pos += 2;
        col++;
        // with >= a smaller width ends the row, a smaller height the frame
        if (col >= w / 2) begin
            col = 0;
            row++;
            if (row >= h) begin
                row = 0;
                luma_pos = 0;
                chroma_pos = 0;
            end
        end
    endfunction

    function void match_byte(logic [y2i_pkg::OFF_W-1:0] off, logic [7:0] val, logic last);
        planar_byte_t b;
        if (due_bytes.size() == 0) begin
            $display("%0t: unexpected byte, offset %h value %h last %b", $time, off, val, last);
            errors++;
            return;
        end
        b = due_bytes.pop_front();
        if (off !== b.offset) begin
            $display("%0t: byte_offset expected %h actual %h", $time, b.offset, off);
            errors++;
        end
        if (val !== b.value) begin
            $display("%0t: byte_value expected %h actual %h", $time, b.value, val);
            errors++;
        end
        if (last !== b.last) begin
            $display("%0t: last_of_run expected %b actual %b", $time, b.last, last);
            errors++;
        end
    endfunction
endclass

module testbench;
    import y2i_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic [BYTE_W-1:0]    luma_first = '0;
    logic [BYTE_W-1:0]    chroma_blue = '0;
    logic [BYTE_W-1:0]    luma_second = '0;
    logic [BYTE_W-1:0]    chroma_red = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [OFF_W-1:0]     byte_offset;
    logic [BYTE_W-1:0]    byte_value;
    logic                 last_of_run;

    i420_tracker tracker = new();
    bit hold_ask = 1'b0;
    int words_sent = 0;
    int bytes_seen = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    yuyv_packed_to_i420_planar dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .luma_first  (luma_first),
        .chroma_blue (chroma_blue),
        .luma_second (luma_second),
        .chroma_red  (chroma_red),
        .empty       (empty),
        .pop         (pop),
        .byte_offset (byte_offset),
        .byte_value  (byte_value),
        .last_of_run (last_of_run)
    );

    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    task automatic send_word(input logic [7:0] y0, input logic [7:0] u,
                             input logic [7:0] y1, input logic [7:0] v);
        int gap;
        // no gaps on the input side for a stretch of words
        if ((words_sent < 120 || words_sent >= 180) && $urandom_range(0, 99) < 10)
            gap = $urandom_range(1, 4);
        else
            gap = 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        luma_first <= y0;
        chroma_blue <= u;
        luma_second <= y1;
        chroma_red <= v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tracker.take_word(y0, u, y1, v);
        words_sent++;
    endtask

    task automatic send_random();
        send_word(any_byte(), any_byte(), any_byte(), any_byte());
    endtask

    // wait for every owed byte, then let the sequencer go quiet
    task automatic settle();
        push <= 1'b0;
        while (tracker.due_bytes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_frame(input bit set_w, input logic [CFG_W-1:0] w,
                             input bit set_h, input logic [CFG_W-1:0] h);
        if (set_w && tracker.width_ok(w)) begin
            cfg_write <= 1'b1;
            cfg_index <= REG_FRAME_WIDTH;
            cfg_data <= w;
            @(posedge clk);
            tracker.width_reg = w;
        end
        if (set_h) begin
            cfg_write <= 1'b1;
            cfg_index <= REG_FRAME_HEIGHT;
            cfg_data <= h;
            @(posedge clk);
            tracker.height_reg = h;
        end
        cfg_write <= 1'b0;
    endtask

    initial begin : result_side
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (pop && !empty) begin
                tracker.match_byte(byte_offset, byte_value, last_of_run);
                bytes_seen++;
            end
            // long hold so the block backs up and raises full
            if (hold_ask) begin
                hold_ask = 1'b0;
                pop <= 1'b0;
                repeat (300) @(posedge clk);
            end
            pop <= (bytes_seen >= 300 && bytes_seen < 450) || $urandom_range(0, 99) >= 10;
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes, then shrink to 4 x 3 in the middle of the first row
        repeat (3) send_random();
        settle();
        set_frame(1'b1, 13'd5, 1'b1, 13'd3);
        while (!tracker.at_frame_start())
            send_random();

        send_word(8'h00, 8'h00, 8'h00, 8'h00);
        send_word(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(8'h00, 8'hFF, 8'h00, 8'hFF);
        send_word(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // odd height: the last row stores chroma but emits none
        send_word(8'h55, 8'hAA, 8'hAA, 8'h55);
        send_word(8'hAA, 8'h55, 8'h55, 8'hAA);
        send_word(8'h01, 8'h01, 8'h80, 8'h00);
        send_word(8'h7F, 8'h03, 8'h80, 8'h01);
        send_word(8'h80, 8'h00, 8'h7F, 8'h00);
        send_word(8'hFE, 8'h04, 8'h01, 8'hFF);
        send_word(8'h12, 8'h34, 8'h56, 8'h78);
        send_word(8'h9A, 8'hBC, 8'hDE, 8'hF0);
        settle();

        // sizes below range clamp to 2 x 2
        set_frame(1'b1, 13'd0, 1'b1, 13'd1);
        repeat (24) send_random();
        settle();

        // width above range clamps to the maximum
        set_frame(1'b1, 13'h1FFF, 1'b1, 13'd2);
        repeat (20) send_random();
        settle();

        // narrow the row mid-frame and use the tallest frame
        set_frame(1'b1, 13'd17, 1'b1, 13'h1FFF);
        hold_ask = 1'b1;
        repeat (60) send_random();
        settle();

        // height below the current row ends the frame when the row ends
        set_frame(1'b0, '0, 1'b1, 13'd3);
        repeat (20) send_random();

        while (words_sent < 280) begin
            settle();
            w = 13'($urandom_range(0, 40));
            h = 13'($urandom_range(0, 9));
            set_frame(1'b1, w, 1'b1, h);
            n = $urandom_range(10, 30);
            repeat (n) send_random();
        end
        settle();
        repeat (20) @(posedge clk);

        if (tracker.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #200000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
